[hdl/lru_handle_pool_unit_macros.svh]
// Assertion macros shared by the LRU handle pool RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef LRU_HANDLE_POOL_UNIT_MACROS_SVH
`define LRU_HANDLE_POOL_UNIT_MACROS_SVH

// Implication checked on every rising edge outside reset
`define LHP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lhp implication check failed");

// Invariant checked on every rising edge outside reset
`define LHP_ASSERT_HOLDS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("lhp invariant check failed");

`endif

[hdl/lhp_pkg.sv]
// Shared types and constants for the LRU handle pool.
// No dependencies; used by lhp_cell, lru_handle_pool_unit and tb_top.
package lhp_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int RANK_W_DEF   = 4;
    localparam int KEY_W        = 64;
    localparam int SLOT_W       = 4;
    localparam int CFG_W        = 5;
    localparam int DATA_W       = 32;
    localparam int PADDR_W      = 3;
    localparam int REG_IDX_W    = PADDR_W - 2;

    localparam logic [CFG_W-1:0]     MAX_ENTRIES_RST = CFG_W'(16);
    localparam logic [REG_IDX_W-1:0] REG_MAX_ENTRIES = '0;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } lhp_state_t;

    // Broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;
        logic upd_en;
        logic hit;
        logic evict;
    } cell_ctrl_t;

    // Per-cell status back to the sequencer
    typedef struct packed {
        logic valid;
        logic match;
        logic victim;
        logic take;
    } cell_stat_t;

endpackage

[hdl/lhp_cell.sv]
// One pool entry: key, valid bit and recency rank, with local compare and update.
// Depends on lhp_pkg; chained through the free-slot priority signal.
module lhp_cell #(
    parameter int RANK_W = lhp_pkg::RANK_W_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lhp_pkg::cell_ctrl_t      ctrl,
    input  logic [lhp_pkg::KEY_W-1:0] key_i,
    input  logic [RANK_W-1:0]        occ_last,
    input  logic [RANK_W-1:0]        hit_rank,
    input  logic                     taken_i,
    output logic                     taken_o,
    output lhp_pkg::cell_stat_t      stat,
    output logic [lhp_pkg::KEY_W-1:0] key_o,
    output logic [RANK_W-1:0]        rank_o
);
    import lhp_pkg::*;

    logic              valid_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [RANK_W-1:0] rank_reg;
    logic              match_reg;
    logic              victim_reg;
    logic              cand;
    logic              take;

    // Free-slot candidate: empty, or the entry being evicted
    assign cand    = !valid_reg || (ctrl.evict && victim_reg);
    assign take    = !ctrl.hit && cand && !taken_i;
    assign taken_o = taken_i || cand;

    assign stat.valid  = valid_reg;
    assign stat.match  = match_reg;
    assign stat.victim = victim_reg;
    assign stat.take   = take;
    assign key_o       = key_reg;
    assign rank_o      = rank_reg;

    // Compare stage: flag key match and oldest entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg  <= 1'b0;
            victim_reg <= 1'b0;
        end else if (ctrl.cmp_en) begin
            match_reg  <= valid_reg && (key_reg == key_i);
            victim_reg <= valid_reg && (rank_reg == occ_last);
        end
    end

    // Update stage: recency aging, eviction, install
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end else if (ctrl.upd_en) begin
            if (ctrl.hit) begin
                if (match_reg) begin
                    rank_reg <= '0;
                end else if (valid_reg && (rank_reg < hit_rank)) begin
                    rank_reg <= rank_reg + RANK_W'(1);
                end
            end else if (take) begin
                valid_reg <= 1'b1;
                rank_reg  <= '0;
            end else if (ctrl.evict && victim_reg) begin
                valid_reg <= 1'b0;
                rank_reg  <= '0;
            end else if (valid_reg) begin
                rank_reg <= rank_reg + RANK_W'(1);
            end
        end
    end

    // Key payload, written only on install
    always_ff @(posedge aclk) begin
        if (ctrl.upd_en && take) begin
            key_reg <= key_i;
        end
    end

endmodule

[hdl/lru_handle_pool_unit.sv]
// LRU handle pool: a row of CAPACITY lhp_cell entries plus sequencer, config and output register.
// A request key is registered, compared in the compare state, and its result registered in the update state.
// The next request is accepted during the update state once the result register is free.
// The cell row sets both states: all keys compare together, then ranks update.
// Reset (aresetn, synchronous): pool empty, max_entries = 16, no result pending.
`include "lru_handle_pool_unit_macros.svh"

module lru_handle_pool_unit #(
    parameter int CAPACITY = lhp_pkg::CAPACITY_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [lhp_pkg::KEY_W-1:0]    s_key,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic [lhp_pkg::SLOT_W-1:0]   m_slot,
    output logic                         m_evicted,
    output logic [lhp_pkg::KEY_W-1:0]    m_evicted_key,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lhp_pkg::PADDR_W-1:0]  paddr,
    input  logic [lhp_pkg::DATA_W-1:0]   pwdata,
    output logic [lhp_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import lhp_pkg::*;

    localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W  = $clog2(CAPACITY + 1);
    localparam int LIM_W  = (OCC_W > CFG_W) ? OCC_W : CFG_W;

    lhp_state_t        state_reg, state_next;
    logic [CFG_W-1:0]  max_entries_reg;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [KEY_W-1:0]  key_reg;
    logic              m_valid_reg;
    logic              m_hit_reg;
    logic [SLOT_W-1:0] m_slot_reg;
    logic              m_evicted_reg;
    logic [KEY_W-1:0]  m_evicted_key_reg;

    cell_ctrl_t        ctrl;
    cell_stat_t        stat    [CAPACITY];
    logic [KEY_W-1:0]  cell_key[CAPACITY];
    logic [RANK_W-1:0] cell_rank[CAPACITY];
    logic [CAPACITY:0] taken_chain;
    logic [CAPACITY-1:0] match_vec, victim_vec, valid_vec;

    logic              s_acc;
    logic              out_free;
    logic              cfg_wr;
    logic              any_hit;
    logic              at_limit;
    logic [LIM_W-1:0]  lim;
    logic [LIM_W-1:0]  cfg_ext;
    logic [OCC_W-1:0]  occ_m1;
    logic [RANK_W-1:0] occ_last;
    logic [RANK_W-1:0] hit_rank;
    logic [KEY_W-1:0]  victim_key;
    logic [SLOT_W-1:0] slot_sel;

    // Handshake
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_UPD) && out_free);
    assign s_acc    = s_valid && s_ready;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= MAX_ENTRIES_RST;
        end else if (cfg_wr && (paddr[PADDR_W-1:2] == REG_MAX_ENTRIES)) begin
            max_entries_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1:2] == REG_MAX_ENTRIES) begin
            prdata = DATA_W'(max_entries_reg);
        end
    end

    // Effective limit, clamped to 1..CAPACITY
    assign cfg_ext = LIM_W'(max_entries_reg);
    always_comb begin
        if (cfg_ext == '0) begin
            lim = LIM_W'(1);
        end else if (cfg_ext > LIM_W'(CAPACITY)) begin
            lim = LIM_W'(CAPACITY);
        end else begin
            lim = cfg_ext;
        end
    end
    assign at_limit = (LIM_W'(occ_reg) >= lim) && (occ_reg != '0);
    assign occ_m1   = occ_reg - OCC_W'(1);
    assign occ_last = occ_m1[RANK_W-1:0];

    // Request key holding register
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            key_reg <= s_key;
        end
    end

    // Sequencer: state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) state_next = ST_CMP;
            end
            ST_CMP: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (out_free) state_next = s_acc ? ST_CMP : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer: cell controls
    always_comb begin
        ctrl.cmp_en = 1'b0;
        ctrl.upd_en = 1'b0;
        unique case (state_reg)
            ST_IDLE: ;
            ST_CMP:  ctrl.cmp_en = 1'b1;
            ST_UPD:  ctrl.upd_en = out_free;
            default: ;
        endcase
        ctrl.hit   = any_hit;
        ctrl.evict = !any_hit && at_limit;
    end

    // Cell row
    assign taken_chain[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        lhp_cell #(
            .RANK_W (RANK_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .key_i    (key_reg),
            .occ_last (occ_last),
            .hit_rank (hit_rank),
            .taken_i  (taken_chain[i]),
            .taken_o  (taken_chain[i+1]),
            .stat     (stat[i]),
            .key_o    (cell_key[i]),
            .rank_o   (cell_rank[i])
        );
        assign match_vec[i]  = stat[i].match;
        assign victim_vec[i] = stat[i].victim;
        assign valid_vec[i]  = stat[i].valid;
    end

    // One-hot selects across the row: hit rank, victim key, slot
    always_comb begin
        hit_rank   = '0;
        victim_key = '0;
        slot_sel   = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (stat[i].match) hit_rank = hit_rank | cell_rank[i];
            if (stat[i].victim && ctrl.evict) victim_key = victim_key | cell_key[i];
            if (stat[i].match || stat[i].take) slot_sel = slot_sel | SLOT_W'(i);
        end
    end
    assign any_hit = |match_vec;

    // Occupancy
    always_comb begin
        occ_next = occ_reg;
        if (ctrl.upd_en && !any_hit && !ctrl.evict) begin
            occ_next = occ_reg + OCC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.upd_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.upd_en) begin
            m_hit_reg         <= any_hit;
            m_slot_reg        <= slot_sel;
            m_evicted_reg     <= ctrl.evict;
            m_evicted_key_reg <= victim_key;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_slot        = m_slot_reg;
    assign m_evicted     = m_evicted_reg;
    assign m_evicted_key = m_evicted_key_reg;

    // Checks
    `LHP_ASSERT_HOLDS(a_occ_matches_valid, aclk, aresetn, $countones(valid_vec) == occ_reg)
    `LHP_ASSERT_IMP(a_single_match, aclk, aresetn, state_reg == ST_UPD, $onehot0(match_vec))
    `LHP_ASSERT_IMP(a_single_victim, aclk, aresetn, state_reg == ST_UPD, $onehot0(victim_vec))
    `LHP_ASSERT_IMP(a_free_slot_on_miss, aclk, aresetn, ctrl.upd_en && !any_hit, taken_chain[CAPACITY])
    `LHP_ASSERT_IMP(a_hit_no_evict, aclk, aresetn, m_valid_reg, !(m_hit_reg && m_evicted_reg))

endmodule

[tb/tb_top.sv]
// Self-checking testbench for lru_handle_pool_unit: LRU pool lookups, hits, misses and evictions.
// Depends on lhp_pkg and the RTL only; predicts each result in-line and scoreboards it.
module tb_top;
    import lhp_pkg::*;

    localparam int POOL_DEPTH     = CAPACITY_DEF;
    localparam int HOT_KEYS       = 24;
    localparam int NUM_PHASES     = 11;
    localparam int PHASE_ITEMS    = 100;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 1'b1;

    // result of one lookup transaction
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_key;
    } lookup_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [KEY_W-1:0]  s_key   = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_hit;
    logic [SLOT_W-1:0] m_slot;
    logic              m_evicted;
    logic [KEY_W-1:0]  m_evicted_key;

    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0]  pwdata  = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // stimulus and scoreboard state
    logic [KEY_W-1:0] key_queue[$];
    lookup_result_t   result_queue[$];
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               rx_stall_req  = 0;
    int               rx_stall_left = 0;
    int               fail_cnt      = 0;

    // predictor copy of the pool
    logic [KEY_W-1:0] pool_key[POOL_DEPTH];
    bit               pool_valid[POOL_DEPTH];
    int               pool_rank[POOL_DEPTH];
    int               pool_count;
    logic [CFG_W-1:0] limit_reg;

    lru_handle_pool_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_slot        (m_slot),
        .m_evicted     (m_evicted),
        .m_evicted_key (m_evicted_key),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // effective limit: zero acts as one, anything above the pool size as the pool size
    function automatic int effective_limit();
        int lim;
        lim = int'(limit_reg);
        if (lim < 1) lim = 1;
        if (lim > POOL_DEPTH) lim = POOL_DEPTH;
        return lim;
    endfunction

    // look up one key, update recency / occupancy, return the expected result
    function automatic lookup_result_t pool_lookup(logic [KEY_W-1:0] key);
        lookup_result_t r;
        int             s;
        int             oldest;
        bit             found;
        r      = '0;
        s      = 0;
        oldest = -1;
        found  = 1'b0;
        for (int i = 0; i < POOL_DEPTH; i++) begin
            if (pool_valid[i] && pool_key[i] == key) begin
                found = 1'b1;
                s     = i;
                break;
            end
        end
        if (found) begin
            // hit: entries newer than this one age by one
            for (int i = 0; i < POOL_DEPTH; i++) begin
                if (pool_valid[i] && i != s && pool_rank[i] < pool_rank[s])
                    pool_rank[i]++;
            end
            pool_rank[s] = 0;
        end else begin
            // miss at or over the limit: drop exactly one, the oldest
            if (pool_count >= effective_limit() && pool_count > 0) begin
                for (int i = 0; i < POOL_DEPTH; i++) begin
                    if (pool_valid[i] && (oldest < 0 || pool_rank[i] > pool_rank[oldest]))
                        oldest = i;
                end
                r.evicted          = 1'b1;
                r.evicted_key      = pool_key[oldest];
                pool_valid[oldest] = 1'b0;
                pool_rank[oldest]  = 0;
                pool_count--;
            end
            // lowest free slot
            for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
                if (!pool_valid[i]) s = i;
            end
            for (int i = 0; i < POOL_DEPTH; i++) begin
                if (pool_valid[i]) pool_rank[i]++;
            end
            pool_key[s]   = key;
            pool_valid[s] = 1'b1;
            pool_rank[s]  = 0;
            pool_count++;
        end
        r.hit  = found;
        r.slot = SLOT_W'(s);
        return r;
    endfunction

    // config mirror: follows every completed register write
    always @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= MAX_ENTRIES_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[PADDR_W-1:2] == REG_MAX_ENTRIES)
                limit_reg <= pwdata[CFG_W-1:0];
        end
    end

    // request driver: predicts on accept, then offers the next queued key
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_key      <= '0;
            pool_count = 0;
            for (int i = 0; i < POOL_DEPTH; i++) begin
                pool_valid[i] = 1'b0;
                pool_rank[i]  = 0;
                pool_key[i]   = '0;
            end
        end else begin
            if (s_valid && s_ready)
                result_queue.push_back(pool_lookup(s_key));
            if (!s_valid || s_ready) begin
                if (key_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_key   <= key_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: scoreboard compare plus receiver back-pressure
    always @(posedge aclk) begin
        lookup_result_t exp_res;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_queue.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fail_cnt++;
                end else begin
                    exp_res = result_queue.pop_front();
                    if (m_hit !== exp_res.hit) begin
                        $error("hit: expected %0d, got %0d", exp_res.hit, m_hit);
                        fail_cnt++;
                    end
                    if (m_slot !== exp_res.slot) begin
                        $error("slot: expected %0d, got %0d", exp_res.slot, m_slot);
                        fail_cnt++;
                    end
                    if (m_evicted !== exp_res.evicted) begin
                        $error("evicted: expected %0d, got %0d", exp_res.evicted, m_evicted);
                        fail_cnt++;
                    end
                    if (m_evicted_key !== exp_res.evicted_key) begin
                        $error("evicted_key: expected %h, got %h",
                               exp_res.evicted_key, m_evicted_key);
                        fail_cnt++;
                    end
                end
            end
            // long hold-off requested by the stimulus, counted here
            if (rx_stall_req != 0) begin
                rx_stall_left = rx_stall_req;
                rx_stall_req  = 0;
            end
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // register write: setup then access cycle
    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait until every queued key went out and every result came back
    task automatic wait_drained();
        @(negedge aclk);
        while (key_queue.size() != 0 || s_valid || result_queue.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // stimulus
    initial begin
        logic [KEY_W-1:0]        hot_key[HOT_KEYS];
        logic [REG_IDX_W-1:0]    phase_reg[NUM_PHASES];
        logic [DATA_W-1:0]       phase_val[NUM_PHASES];
        int                      working_set;

        phase_reg = '{REG_MAX_ENTRIES, REG_MAX_ENTRIES, REG_MAX_ENTRIES, REG_MAX_ENTRIES,
                      REG_MAX_ENTRIES, REG_MAX_ENTRIES, REG_UNMAPPED, REG_MAX_ENTRIES,
                      REG_MAX_ENTRIES, REG_MAX_ENTRIES, REG_MAX_ENTRIES};
        // over the pool size, lowered under a full pool, zero, one, full, high junk bits,
        // unmapped register (ignored), then mid values
        phase_val = '{32'd31, 32'd2, 32'd0, 32'd1, 32'd16, 32'hFFFF_FFE7, 32'd3,
                      32'd4, 32'd12, 32'h0000_002D, 32'd15};
        foreach (hot_key[i]) hot_key[i] = {$urandom, $urandom};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: sender idles lightly, receiver heavily
        @(negedge aclk);
        send_idle_pct = 14;
        recv_idle_pct = 87;
        key_queue.push_back('0);
        key_queue.push_back('1);
        key_queue.push_back('0);
        key_queue.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        key_queue.push_back(64'h5555_5555_5555_5555);
        for (int i = 1; i <= 12; i++)
            key_queue.push_back(64'h0123_4567_89AB_0000 + KEY_W'(i));
        // pool full at reset limit: new keys evict the oldest
        key_queue.push_back(64'h8000_0000_0000_0000);
        key_queue.push_back(64'h5555_5555_5555_5555);
        key_queue.push_back(64'h0000_0000_0000_0001);
        key_queue.push_back('1);
        wait_drained();

        // random phases, one configuration write each
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 4) begin
                send_idle_pct = 87;
                recv_idle_pct = 14;
            end else if (p == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            cfg_write(phase_reg[p], phase_val[p]);
            @(negedge aclk);
            for (int i = 0; i < 4; i++) hot_key[$urandom_range(HOT_KEYS - 1)] = {$urandom, $urandom};
            working_set = effective_limit() + 3;
            if (working_set > HOT_KEYS) working_set = HOT_KEYS;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(99) < 75)
                    key_queue.push_back(hot_key[$urandom_range(working_set - 1)]);
                else
                    key_queue.push_back({$urandom, $urandom});
            end
            wait_drained();
        end

        // back-pressure: receiver stalls long while the sender keeps offering
        rx_stall_req = 300;
        for (int i = 0; i < 40; i++)
            key_queue.push_back(hot_key[$urandom_range(HOT_KEYS - 1)]);
        wait_drained();

        repeat (10) @(posedge aclk);
        if (fail_cnt == 0 && result_queue.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_CYCLES * 20);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
